// ----- rtl/core/dtb_pkg.sv -----
// Shared types and constants for the decade-prescaled timer bank.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package dtb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int NUM_DECADES = 4;
    localparam int DECADE_BASE = 10;

    // Field widths of the transfer payload
    localparam int REQ_W   = 2;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 8;
    localparam int POWER_W = 3;

    // Bank index width; the bank is sized so this equals INDEX_W
    localparam int TIDX_W  = $clog2(NUM_TIMERS);
    localparam int DIGIT_W = $clog2(DECADE_BASE);

    // Last decade value before the wrap
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(DECADE_BASE - 1);

    // Highest index allocate may hand out
    localparam logic [TIDX_W-1:0] TIMER_LAST = TIDX_W'(NUM_TIMERS - 1);

    // Saturation bound for stored divider powers
    localparam logic [POWER_W-1:0] POWER_MAX = POWER_W'(NUM_DECADES);

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_SET   = 2'd2,
        REQ_CHECK = 2'd3
    } req_t;

    // One request as it leaves the input register
    typedef struct packed {
        logic               fire;
        req_t               req;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic [POWER_W-1:0] power;
    } cmd_t;

    // Gate vector: bit p is high when decades 0..p-1 are all zero after a tick
    typedef logic [NUM_DECADES:0] gate_t;

endpackage

`default_nettype wire

// ----- rtl/core/dtb_prescaler.sv -----
// Decade prescaler chain: ripple-carry BCD-style counters.
// Depends on dtb_pkg.
`default_nettype none

module dtb_prescaler (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          tick_en,
    output dtb_pkg::gate_t     gate
);
    import dtb_pkg::*;

    logic [DIGIT_W-1:0] decade_reg  [NUM_DECADES];
    logic [DIGIT_W-1:0] decade_next [NUM_DECADES];
    logic [NUM_DECADES:0] carry;

    // Ripple increment with wrap at the base
    always_comb begin
        carry[0] = 1'b1;
        for (int d = 0; d < NUM_DECADES; d++) begin
            if (carry[d]) begin
                if (decade_reg[d] == DIGIT_MAX) begin
                    decade_next[d] = '0;
                    carry[d+1]     = 1'b1;
                end else begin
                    decade_next[d] = decade_reg[d] + 1'b1;
                    carry[d+1]     = 1'b0;
                end
            end else begin
                decade_next[d] = decade_reg[d];
                carry[d+1]     = 1'b0;
            end
        end
    end

    // Gates use the post-tick decade values
    always_comb begin
        gate[0] = 1'b1;
        for (int d = 0; d < NUM_DECADES; d++) begin
            gate[d+1] = gate[d] & (decade_next[d] == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < NUM_DECADES; d++) begin
                decade_reg[d] <= '0;
            end
        end else if (tick_en) begin
            for (int d = 0; d < NUM_DECADES; d++) begin
                decade_reg[d] <= decade_next[d];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dtb_timer_bank.sv -----
// Timer storage: counts, divider powers, allocation pointer, check logic.
// Depends on dtb_pkg; gate vector comes from dtb_prescaler.
`default_nettype none

module dtb_timer_bank (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dtb_pkg::cmd_t               cmd,
    input  wire dtb_pkg::gate_t              gate,
    output logic [dtb_pkg::INDEX_W-1:0]      alloc_index,
    output logic                             expired
);
    import dtb_pkg::*;

    logic [VALUE_W-1:0] count_reg  [NUM_TIMERS];
    logic [VALUE_W-1:0] count_next [NUM_TIMERS];
    logic [POWER_W-1:0] div_reg    [NUM_TIMERS];
    logic [POWER_W-1:0] div_next   [NUM_TIMERS];
    logic [TIDX_W-1:0]  highest_reg;
    logic [TIDX_W-1:0]  highest_next;
    logic [TIDX_W-1:0]  grant;
    logic [TIDX_W-1:0]  addr;
    logic [POWER_W-1:0] power_sat;
    logic               can_alloc;

    assign addr      = TIDX_W'(cmd.index);
    assign can_alloc = (highest_reg < TIMER_LAST);
    assign grant     = highest_reg + 1'b1;
    assign power_sat = (cmd.power > POWER_MAX) ? POWER_MAX : cmd.power;

    always_comb begin
        highest_next = highest_reg;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            count_next[k] = count_reg[k];
            div_next[k]   = div_reg[k];
        end
        if (cmd.fire) begin
            case (cmd.req)
                REQ_TICK: begin
                    for (int k = 0; k < NUM_TIMERS; k++) begin
                        if ((TIDX_W'(k) <= highest_reg) && (count_reg[k] != '0)
                                && gate[div_reg[k]]) begin
                            count_next[k] = count_reg[k] - 1'b1;
                        end
                    end
                end
                REQ_ALLOC: begin
                    if (can_alloc) begin
                        highest_next   = grant;
                        div_next[grant] = power_sat;
                    end
                end
                REQ_SET: begin
                    count_next[addr] = cmd.value;
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields, from pre-update state
    always_comb begin
        alloc_index = '0;
        expired     = 1'b0;
        case (cmd.req)
            REQ_ALLOC: begin
                if (can_alloc) begin
                    alloc_index = INDEX_W'(grant);
                end
            end
            REQ_CHECK: begin
                expired = (count_reg[addr] == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_reg <= '0;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                count_reg[k] <= '0;
                div_reg[k]   <= '0;
            end
        end else begin
            highest_reg <= highest_next;
            for (int k = 0; k < NUM_TIMERS; k++) begin
                count_reg[k] <= count_next[k];
                div_reg[k]   <= div_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/decade_prescaled_timer_bank_top.sv -----
// A request is held in the input register and executes as it moves to the result register.
// Throughput: one request per cycle while m_ready keeps the result register draining; a
//   held request waits in the input register while the result register is stalled.
// Reset: aresetn synchronous, active low; clears all timer counts, divider
//   powers, decades, allocation pointer and both valid flags.
// Depends on dtb_pkg, dtb_prescaler, dtb_timer_bank.
`default_nettype none

module decade_prescaled_timer_bank_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // request channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [dtb_pkg::REQ_W-1:0]   s_req_type,
    input  wire logic [dtb_pkg::INDEX_W-1:0] s_timer_index,
    input  wire logic [dtb_pkg::VALUE_W-1:0] s_load_value,
    input  wire logic [dtb_pkg::POWER_W-1:0] s_div_power,
    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [dtb_pkg::INDEX_W-1:0]      m_alloc_index,
    output logic                             m_expired
);
    import dtb_pkg::*;

    // Input register: holds one accepted transfer until it executes
    logic               in_valid_reg;
    logic [REQ_W-1:0]   in_req_reg;
    logic [INDEX_W-1:0] in_index_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic [POWER_W-1:0] in_power_reg;

    // Result register
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_alloc_reg;
    logic               out_expired_reg;

    logic               advance;
    logic               s_fire;
    cmd_t               cmd;
    gate_t              gate;
    logic [INDEX_W-1:0] bank_alloc;
    logic               bank_expired;

    // The held request executes (updates state) exactly when the result
    // register can take its result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    assign cmd.fire  = advance;
    assign cmd.req   = req_t'(in_req_reg);
    assign cmd.index = in_index_reg;
    assign cmd.value = in_value_reg;
    assign cmd.power = in_power_reg;

    dtb_prescaler u_prescaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance && (cmd.req == REQ_TICK)),
        .gate    (gate)
    );

    dtb_timer_bank u_bank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .gate        (gate),
        .alloc_index (bank_alloc),
        .expired     (bank_expired)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg   <= s_req_type;
            in_index_reg <= s_timer_index;
            in_value_reg <= s_load_value;
            in_power_reg <= s_div_power;
        end
        if (advance) begin
            out_alloc_reg   <= bank_alloc;
            out_expired_reg <= bank_expired;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_alloc_index = out_alloc_reg;
    assign m_expired     = out_expired_reg;

    // A result never carries both a grant and an expiry
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_expired_reg && (out_alloc_reg != '0)))
        else $error("result carries both grant and expired");

    // An executed request always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("executed request produced no result");

    // A held request that cannot execute is kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("held request dropped");

endmodule

`default_nettype wire

// ----- tb/decade_prescaled_timer_bank_top_test.sv -----
// Testbench for decade_prescaled_timer_bank_top: directed and random requests with
// bursty input and stalling output, checked against a predictor of the timer bank.
// Depends on dtb_pkg and the block's RTL.
`timescale 1ns / 1ps

module decade_prescaled_timer_bank_top_test;

    import dtb_pkg::*;

    // Predicts the timer bank and checks its results in order
    class bank_scoreboard;

        typedef struct {
            logic [INDEX_W-1:0] alloc_index;
            logic               expired;
        } bank_result_t;

        logic [VALUE_W-1:0] timer_count  [NUM_TIMERS];
        logic [POWER_W-1:0] timer_power  [NUM_TIMERS];
        logic [DIGIT_W-1:0] decade_digit [NUM_DECADES];
        int unsigned        top_alloc;
        bank_result_t       expected_results[$];
        int unsigned        results_seen;
        int unsigned        mismatch_count;

        function new();
            foreach (timer_count[k]) begin
                timer_count[k] = '0;
                timer_power[k] = '0;
            end
            foreach (decade_digit[d]) decade_digit[d] = '0;
            top_alloc      = 0;
            results_seen   = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // Ripple the decade chain, then count down every gated timer
        function void advance_tick();
            bit carry;
            bit gate_open;
            carry = 1'b1;
            foreach (decade_digit[d]) begin
                if (carry) begin
                    if (decade_digit[d] == DIGIT_MAX) begin
                        decade_digit[d] = '0;
                    end else begin
                        decade_digit[d] = decade_digit[d] + 1'b1;
                        carry = 1'b0;
                    end
                end
            end
            for (int k = 0; k <= top_alloc && k < NUM_TIMERS; k++) begin
                if (timer_count[k] != '0) begin
                    gate_open = 1'b1;
                    for (int d = 0; d < NUM_DECADES; d++)
                        if (d < timer_power[k] && decade_digit[d] != '0)
                            gate_open = 1'b0;
                    if (gate_open)
                        timer_count[k] = timer_count[k] - 1'b1;
                end
            end
        endfunction

        function void note_request(req_t req, logic [INDEX_W-1:0] idx,
                                   logic [VALUE_W-1:0] val, logic [POWER_W-1:0] pw);
            bank_result_t res;
            res.alloc_index = '0;
            res.expired     = 1'b0;
            case (req)
                REQ_TICK: begin
                    advance_tick();
                end
                REQ_ALLOC: begin
                    if (top_alloc < NUM_TIMERS - 1) begin
                        top_alloc++;
                        timer_power[top_alloc] = (pw > POWER_MAX) ? POWER_MAX : pw;
                        res.alloc_index = INDEX_W'(top_alloc);
                    end
                end
                REQ_SET: begin
                    if (idx < NUM_TIMERS)
                        timer_count[idx] = val;
                end
                default: begin
                    res.expired = (idx < NUM_TIMERS) && (timer_count[idx] == '0);
                end
            endcase
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, msg);
        endtask

        task check_result(logic [INDEX_W-1:0] alloc_index, logic expired);
            bank_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer alloc_index=%0d expired=%0b",
                                          alloc_index, expired));
            end else begin
                want = expected_results.pop_front();
                if (alloc_index !== want.alloc_index)
                    report_mismatch($sformatf("alloc_index expected %0d got %0d",
                                              want.alloc_index, alloc_index));
                if (expired !== want.expired)
                    report_mismatch($sformatf("expired expected %0b got %0b",
                                              want.expired, expired));
            end
            results_seen++;
        endtask

    endclass

    localparam int RANDOM_ITEMS = 1630;
    // Far beyond the longest quiet stretch that sender gaps and receiver stalls can make
    localparam int QUIET_LIMIT  = 4000;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [REQ_W-1:0]     s_req_type    = REQ_TICK;
    logic [INDEX_W-1:0]   s_timer_index = '0;
    logic [VALUE_W-1:0]   s_load_value  = '0;
    logic [POWER_W-1:0]   s_div_power   = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [INDEX_W-1:0]   m_alloc_index;
    logic                 m_expired;

    int unsigned          quiet_cycles  = 0;
    int unsigned          rx_cycle      = 0;

    bank_scoreboard       sb = new();

    decade_prescaled_timer_bank_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_timer_index (s_timer_index),
        .s_load_value  (s_load_value),
        .s_div_power   (s_div_power),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_alloc_index (m_alloc_index),
        .m_expired     (m_expired)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // Drive one request from the falling edge and hold it until the transfer.
    // Valid stays high on return so back-to-back calls form a burst.
    task automatic send_request(req_t req, logic [INDEX_W-1:0] idx,
                                logic [VALUE_W-1:0] val, logic [POWER_W-1:0] pw);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_timer_index <= idx;
        s_load_value  <= val;
        s_div_power   <= pw;
        do @(posedge aclk); while (!s_ready);
        // The predictor advances at the accepting edge, in request order
        sb.note_request(req, idx, val, pw);
    endtask

    // Sender gap: valid held low for the requested idle time
    task automatic idle_sender(int unsigned cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Short directed sequence: index and value extremes, every request kind,
    // power saturation, timer zero, and a loaded timer that is not allocated.
    task automatic run_directed();
        send_request(REQ_CHECK, 4'd0,  8'd0,   3'd0);   // timer zero expired after reset
        send_request(REQ_SET,   4'd0,  8'd255, 3'd0);
        send_request(REQ_CHECK, 4'd0,  8'd0,   3'd0);
        send_request(REQ_TICK,  4'd15, 8'd255, 3'd7);   // timer zero counts down, power 0
        send_request(REQ_SET,   4'd15, 8'd1,   3'd0);   // above the allocation pointer
        send_request(REQ_TICK,  4'd0,  8'd0,   3'd0);
        send_request(REQ_CHECK, 4'd15, 8'd0,   3'd0);   // must still hold its count
        send_request(REQ_ALLOC, 4'd0,  8'd0,   3'd7);   // saturates to the top power
        send_request(REQ_ALLOC, 4'd9,  8'd77,  3'd0);
        send_request(REQ_SET,   4'd2,  8'd1,   3'd0);
        send_request(REQ_TICK,  4'd0,  8'd0,   3'd0);
        send_request(REQ_CHECK, 4'd2,  8'd0,   3'd0);   // power 0 timer reached zero
        send_request(REQ_ALLOC, 4'd0,  8'd0,   3'd5);   // saturates
        send_request(REQ_ALLOC, 4'd0,  8'd0,   3'd1);
        send_request(REQ_ALLOC, 4'd0,  8'd0,   3'd2);
        send_request(REQ_ALLOC, 4'd0,  8'd0,   3'd3);
        send_request(REQ_ALLOC, 4'd0,  8'd0,   3'd4);
        send_request(REQ_SET,   4'd4,  8'd2,   3'd0);
        send_request(REQ_SET,   4'd1,  8'd0,   3'd0);
        send_request(REQ_CHECK, 4'd1,  8'd0,   3'd0);
        send_request(REQ_TICK,  4'd0,  8'd0,   3'd0);
        send_request(REQ_CHECK, 4'd4,  8'd0,   3'd0);   // power 1: decade 0 not yet wrapped
    endtask

    // Random traffic in bursts; ticks dominate so the decade chain wraps
    // several times and divided timers actually count down.
    task automatic run_random(int unsigned count);
        int unsigned        sent;
        int unsigned        burst;
        int unsigned        roll;
        req_t               req;
        logic [VALUE_W-1:0] val;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < count) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    req = REQ_TICK;
                else if (roll < 59)
                    req = REQ_ALLOC;
                else if (roll < 79)
                    req = REQ_SET;
                else
                    req = REQ_CHECK;
                // mostly short counts so timers expire within the run
                if ($urandom_range(0, 9) < 7)
                    val = VALUE_W'($urandom_range(0, 4));
                else
                    val = VALUE_W'($urandom_range(0, 255));
                send_request(req, INDEX_W'($urandom_range(0, 15)), val,
                             POWER_W'($urandom_range(0, 7)));
                burst--;
                sent++;
            end
            // some bursts run straight into the next one
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 7));
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Receiver backpressure: cycles through free-running, random stalls,
    // a periodic pattern and longer stall runs.
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 2) != 0);
            2: m_ready <= (rx_cycle % 5 != 0);
            default: m_ready <= ((rx_cycle % 16) >= 6);
        endcase
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_alloc_index, m_expired);
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(RANDOM_ITEMS);

        // Drain: every expected transfer arrives, then the bench waits on so that any
        // stray result is still caught.
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
